// File: src/rta_pkg.sv
package rta_pkg;

    localparam int IN_W           = 32;
    localparam int RADIX_W        = 5;
    localparam int CHAR_W         = 7;
    localparam int DIGIT_W        = 4;
    localparam int NUMBER_WIDTH   = 32;
    localparam int HEX_PAD_DIGITS = 8;
    localparam int MAX_DIGITS     = NUMBER_WIDTH;
    localparam int CNT_MAX        = (MAX_DIGITS > HEX_PAD_DIGITS) ? MAX_DIGITS : HEX_PAD_DIGITS;
    localparam int CNT_W          = $clog2(CNT_MAX + 1);
    localparam int PAD_W          = $clog2(HEX_PAD_DIGITS + 1);
    localparam int BIT_CNT_W      = $clog2(NUMBER_WIDTH);

    localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_HEX = RADIX_W'(16);

    localparam logic [CHAR_W-1:0] CHAR_ZERO = CHAR_W'(8'h30);

    typedef logic [CHAR_W-1:0] t_char_table [16];

    localparam t_char_table DIGIT_CHARS = '{
        7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
        7'h38, 7'h39, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66
    };

    typedef struct packed {
        logic                    done;
        logic [NUMBER_WIDTH-1:0] quot;
        logic [DIGIT_W-1:0]      rem;
    } t_div_status;

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        return DIGIT_CHARS[d];
    endfunction

endpackage

// File: src/rta_div.sv
module rta_div (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic [rta_pkg::NUMBER_WIDTH-1:0]     i_dividend,
    input  logic [rta_pkg::RADIX_W-1:0]          i_divisor,
    output rta_pkg::t_div_status                 o_status
);
    import rta_pkg::*;

    logic                    r_busy;
    logic                    r_done;
    logic [BIT_CNT_W-1:0]    r_cnt;
    logic [NUMBER_WIDTH-1:0] r_quot;
    logic [RADIX_W-1:0]      r_rem;
    logic [RADIX_W-1:0]      r_div;
    logic [RADIX_W:0]        w_trial;
    logic                    w_fits;

    // one quotient bit per cycle, restoring
    assign w_trial = {r_rem, r_quot[NUMBER_WIDTH-1]};
    assign w_fits  = (w_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + BIT_CNT_W'(1);
            if (r_cnt == BIT_CNT_W'(NUMBER_WIDTH - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[NUMBER_WIDTH-2:0], w_fits};
            r_rem  <= w_fits ? RADIX_W'(w_trial - {1'b0, r_div}) : w_trial[RADIX_W-1:0];
        end
    end

    assign o_status.done = r_done;
    assign o_status.quot = r_quot;
    assign o_status.rem  = r_rem[DIGIT_W-1:0];

endmodule

// File: src/rta_stack.sv
module rta_stack (
    input  logic                          i_clk,
    input  logic                          i_push,
    input  logic                          i_pop,
    input  logic [rta_pkg::DIGIT_W-1:0]   i_digit,
    output logic [rta_pkg::DIGIT_W-1:0]   o_top
);
    import rta_pkg::*;

    logic [DIGIT_W-1:0] r_stack [MAX_DIGITS];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_stack[0] <= i_digit;
            for (int i = 1; i < MAX_DIGITS; i++) begin
                r_stack[i] <= r_stack[i-1];
            end
        end else if (i_pop) begin
            for (int i = 0; i < MAX_DIGITS - 1; i++) begin
                r_stack[i] <= r_stack[i+1];
            end
        end
    end

    assign o_top = r_stack[0];

endmodule

// File: src/radix_to_ascii_digits.sv
// channel | direction | handshake           | payload
// request | in        | i_valid / o_ready   | i_number_value, i_radix
// digit   | out       | o_valid / i_ready   | o_digit_char, o_last_digit
//
// Each digit comes from one division pass in the bit-serial divider; digits
// stack up least significant first, then leave one per cycle unless the
// output stalls (hex pads first).
// One request at a time; o_ready is high while no request is in work.
// Synchronous active-low reset clears control state only.
// A stalled output holds the character; the next digit waits in the stack.
module radix_to_ascii_digits (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [rta_pkg::IN_W-1:0]     i_number_value,
    input  logic [rta_pkg::RADIX_W-1:0]  i_radix,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [rta_pkg::CHAR_W-1:0]   o_digit_char,
    output logic                         o_last_digit
);
    import rta_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [RADIX_W-1:0]  r_radix, n_radix;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [PAD_W-1:0]    r_pad, n_pad;
    logic                r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]   r_char, n_char;
    logic                r_last, n_last;

    logic                    w_accept;
    logic                    w_start;
    logic [NUMBER_WIDTH-1:0] w_dividend;
    logic [RADIX_W-1:0]      w_radix_clamped;
    logic [CNT_W-1:0]        w_count_inc;
    logic                    w_push;
    logic                    w_pop;
    logic                    w_slot_free;
    logic [DIGIT_W-1:0]      w_top;
    t_div_status             w_div;

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;

    assign w_radix_clamped = (i_radix < RADIX_MIN) ? RADIX_MIN :
                             (i_radix > RADIX_HEX) ? RADIX_HEX : i_radix;

    assign w_count_inc = r_count + CNT_W'(1);
    assign w_slot_free = !r_out_valid || i_ready;

    always_comb begin
        n_state     = r_state;
        n_radix     = r_radix;
        n_count     = r_count;
        n_pad       = r_pad;
        n_out_valid = r_out_valid && !i_ready;
        n_char      = r_char;
        n_last      = r_last;
        w_start     = 1'b0;
        w_dividend  = NUMBER_WIDTH'(i_number_value);
        w_push      = 1'b0;
        w_pop       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_radix = w_radix_clamped;
                    n_count = '0;
                    w_start = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div.done) begin
                    w_push  = 1'b1;
                    n_count = w_count_inc;
                    if (w_div.quot != '0) begin
                        w_start    = 1'b1;
                        w_dividend = w_div.quot;
                    end else begin
                        if (r_radix == RADIX_HEX && w_count_inc < CNT_W'(HEX_PAD_DIGITS)) begin
                            n_pad = PAD_W'(HEX_PAD_DIGITS) - PAD_W'(w_count_inc);
                        end else begin
                            n_pad = '0;
                        end
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    if (r_pad != '0) begin
                        n_char = CHAR_ZERO;
                        n_last = 1'b0;
                        n_pad  = r_pad - PAD_W'(1);
                    end else begin
                        w_pop   = 1'b1;
                        n_char  = digit_to_ascii(w_top);
                        n_last  = (r_count == CNT_W'(1));
                        n_count = r_count - CNT_W'(1);
                        if (r_count == CNT_W'(1)) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pad       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pad       <= n_pad;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_radix <= n_radix;
        r_char  <= n_char;
        r_last  <= n_last;
    end

    rta_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_accept ? w_radix_clamped : r_radix),
        .o_status   (w_div)
    );

    rta_stack u_stack (
        .i_clk   (i_clk),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .i_digit (w_div.rem),
        .o_top   (w_top)
    );

    assign o_valid      = r_out_valid;
    assign o_digit_char = r_char;
    assign o_last_digit = r_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_DIGITS))
        else $error("digit count beyond stack depth");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_count == '0))
        else $error("idle with digits left in stack");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.done |-> (r_state == S_DIV))
        else $error("divider finished outside digit phase");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=>
            (o_valid && $stable(o_digit_char) && $stable(o_last_digit)))
        else $error("output changed while stalled");

endmodule
